// ===== sv/fqs_pkg.sv =====
// Shared types and codes for the searchable FIFO queue.
package fqs_pkg;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_SEARCH  = 2'd2,
        ACT_DISPLAY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;     // take the input word into the item registers
        logic    push;        // write the item value at the tail
        logic    pop;         // retire the head entry
        logic    scan_first;  // read the head entry, start the position count
        logic    scan_next;   // read the entry at the walk pointer
        logic    load;        // load the result register
        status_t res_status;
        logic    res_data;    // result data comes from the store read
        logic    res_pos;     // result position comes from the walk count
        logic    res_last;
    } fqs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    match;       // registered store read equals the sought value
        logic    scan_done;   // the entry just read is the newest one
        logic    out_free;    // the result register can take a word
    } fqs_stat_t;

endpackage

// ===== sv/fqs_ifs.sv =====
// Valid/ready channel interfaces for requests and responses.
interface fqs_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic signed [31:0] value;

    modport source (output valid, action, value, input ready);
    modport sink (input valid, action, value, output ready);
endinterface

interface fqs_rsp_if #(
    parameter int POS_W = 5
);
    logic                valid;
    logic                ready;
    logic        [1:0]   status;
    logic signed [31:0]  data;
    logic [POS_W-1:0]    position;
    logic                last;

    modport source (output valid, status, data, position, last, input ready);
    modport sink (input valid, status, data, position, last, output ready);
endinterface

// ===== sv/fifo_queue_with_search.sv =====
// Top level of the searchable FIFO queue of signed 32-bit words.
//
// Requests arrive on the req channel: an action (enqueue, dequeue, search,
// display) and a value. Responses leave on the rsp channel as words of
// status, data, position and last; the final word of each request has last
// set. A word moves when valid and ready are both high.
// The block works on one request at a time and raises req.ready only when
// the previous request has been fully handed to the response register.
// Enqueue and an empty-queue response go from acceptance to the response
// word through the idle and execute states; dequeue adds the read state
// because the store read is registered. Search walks the store one entry
// per cycle and reports the position k of the first match, or not found
// after all n entries. Display emits one word per cycle while the receiver
// takes them, n words in all. A new request can be accepted in the cycle
// after the last word of the previous one loads.
// The response register lets one word wait while the next is prepared;
// when the receiver stalls, a display walk holds in place and resumes with it.
// Reset empties the queue (pointers and count to zero) and drops any
// pending response; the store contents need no clearing.
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic         clk,
    input logic         rst_n,
    fqs_req_if.sink     req,
    fqs_rsp_if.source   rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fqs_cmd_t  cmd;
    fqs_stat_t stat;

    fqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fqs_datapath #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_action    (req.action),
        .in_value     (req.value),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_status   (rsp.status),
        .out_data     (rsp.data),
        .out_position (rsp.position),
        .out_last     (rsp.last)
    );

endmodule

// ===== sv/fqs_datapath.sv =====
// Ring store, pointers, entry count, walk counter and result register.
module fqs_datapath
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fqs_cmd_t           cmd,
    output fqs_stat_t          stat,
    input  logic        [1:0]  in_action,
    input  logic signed [31:0] in_value,
    input  logic               out_ready,
    output logic               out_valid,
    output logic        [1:0]  out_status,
    output logic signed [31:0] out_data,
    output logic [CNT_W-1:0]   out_position,
    output logic               out_last
);

    logic [31:0] mem [DEPTH];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] walk_reg, walk_next;
    action_t          action_reg;
    logic [31:0]      value_reg;
    logic [31:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    logic               out_valid_reg, out_valid_next;
    logic        [1:0]  out_status_reg;
    logic signed [31:0] out_data_reg;
    logic [CNT_W-1:0]   out_pos_reg;
    logic               out_last_reg;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        if (s == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    // Item registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            action_reg <= ACT_ENQUEUE;
        end else if (cmd.capture) begin
            action_reg <= action_t'(in_action);
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            value_reg <= in_value;
        end
    end

    // Store: one write port at the tail, one registered read port.
    assign rd_en   = cmd.scan_first | cmd.scan_next;
    assign rd_addr = cmd.scan_first ? head_reg : ptr_reg;

    always_ff @(posedge clk) begin
        if (cmd.push) begin
            mem[tail_reg] <= value_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        walk_next  = walk_reg;
        if (cmd.push) begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop) begin
            head_next  = next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.scan_first) begin
            ptr_next  = next_slot(head_reg);
            walk_next = CNT_W'(1);
        end else if (cmd.scan_next) begin
            ptr_next  = next_slot(ptr_reg);
            walk_next = walk_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            walk_reg  <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            walk_reg  <= walk_next;
        end
    end

    // Result register: a new word may load while the current one is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            out_status_reg <= cmd.res_status;
            out_data_reg   <= cmd.res_data ? rd_data_reg : '0;
            out_pos_reg    <= cmd.res_pos ? walk_reg : '0;
            out_last_reg   <= cmd.res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_data     = out_data_reg;
    assign out_position = out_pos_reg;
    assign out_last     = out_last_reg;

    assign stat.action    = action_reg;
    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.match     = (rd_data_reg == value_reg);
    assign stat.scan_done = (walk_reg == count_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== sv/fqs_ctrl.sv =====
// Controller state machine that sequences each queue action.
module fqs_ctrl
    import fqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fqs_stat_t stat,
    output fqs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.action == ACT_ENQUEUE) begin
                    if (stat.out_free) begin
                        cmd.load     = 1'b1;
                        cmd.res_last = 1'b1;
                        if (stat.full) begin
                            cmd.res_status = ST_FULL;
                        end else begin
                            cmd.res_status = ST_OK;
                            cmd.push       = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end else if (stat.empty) begin
                    if (stat.out_free) begin
                        cmd.load       = 1'b1;
                        cmd.res_status = ST_EMPTY;
                        cmd.res_last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    // Dequeue reads the head and retires it in the same cycle.
                    cmd.scan_first = 1'b1;
                    cmd.pop        = (stat.action == ACT_DEQUEUE);
                    state_next     = S_READ;
                end
            end
            S_READ: begin
                unique case (stat.action)
                    ACT_DEQUEUE: begin
                        if (stat.out_free) begin
                            cmd.load       = 1'b1;
                            cmd.res_status = ST_OK;
                            cmd.res_data   = 1'b1;
                            cmd.res_last   = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    ACT_SEARCH: begin
                        if (stat.match) begin
                            if (stat.out_free) begin
                                cmd.load       = 1'b1;
                                cmd.res_status = ST_OK;
                                cmd.res_pos    = 1'b1;
                                cmd.res_last   = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end else if (stat.scan_done) begin
                            if (stat.out_free) begin
                                cmd.load       = 1'b1;
                                cmd.res_status = ST_NOT_FOUND;
                                cmd.res_last   = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end else begin
                            cmd.scan_next = 1'b1;
                        end
                    end
                    ACT_DISPLAY: begin
                        // The next read waits until the current word is emitted.
                        if (stat.out_free) begin
                            cmd.load       = 1'b1;
                            cmd.res_status = ST_OK;
                            cmd.res_data   = 1'b1;
                            cmd.res_pos    = 1'b1;
                            cmd.res_last   = stat.scan_done;
                            if (stat.scan_done) begin
                                state_next = S_IDLE;
                            end else begin
                                cmd.scan_next = 1'b1;
                            end
                        end
                    end
                    ACT_ENQUEUE: begin
                        state_next = S_IDLE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== test/fifo_queue_with_search_tb.sv =====
// Self-checking testbench for the searchable FIFO queue: directed table, then random traffic.
module fifo_queue_with_search_tb;
    import fqs_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 308;
    localparam int CYCLE_LIMIT = 600000;

    // One response word as the block should present it.
    typedef struct packed {
        status_t     status;
        logic [31:0] data;
        logic [4:0]  position;
        logic        last;
    } rsp_word_t;

    // One row of the directed table; repeated rows step the value by one.
    typedef struct packed {
        action_t     act;
        logic [31:0] word;
        int          reps;
        bit          typed;
        status_t     status;
        logic [31:0] data;
        logic [4:0]  position;
    } stim_row_t;

    logic clk;
    logic rst_n;

    fqs_req_if req_ch ();
    fqs_rsp_if #(.POS_W(5)) rsp_ch ();

    fifo_queue_with_search #(
        .DEPTH(DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the queue contents, kept in step with accepted requests.
    logic [31:0] mirror_entries [DEPTH];
    int          mirror_head;
    int          mirror_tail;
    int          mirror_count;

    rsp_word_t   awaited_words [$];
    int          error_count;
    int          cycle_count;
    bit          long_hold_req;
    bit          quiet_run;

    stim_row_t directed_rows [0:24] = '{
        '{ACT_DEQUEUE, 32'h0000_0000,  1, 1'b1, ST_EMPTY,     32'h0000_0000, 5'd0},
        '{ACT_SEARCH,  32'h0000_0000,  1, 1'b1, ST_EMPTY,     32'h0000_0000, 5'd0},
        '{ACT_DISPLAY, 32'h0000_0000,  1, 1'b1, ST_EMPTY,     32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'h8000_0000,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'h7FFF_FFFF,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'h0000_0000,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'hFFFF_FFFF,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_SEARCH,  32'h7FFF_FFFF,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd2},
        '{ACT_SEARCH,  32'h7FFF_FFFE,  1, 1'b1, ST_NOT_FOUND, 32'h0000_0000, 5'd0},
        '{ACT_SEARCH,  32'hFFFF_FFFF,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd4},
        '{ACT_SEARCH,  32'h8000_0000,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd1},
        '{ACT_DISPLAY, 32'h0000_0000,  1, 1'b0, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_DEQUEUE, 32'h0000_0000,  1, 1'b1, ST_OK,        32'h8000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'h0000_1000, 13, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'h0000_0005,  1, 1'b1, ST_FULL,      32'h0000_0000, 5'd0},
        '{ACT_SEARCH,  32'h0000_100C,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd16},
        '{ACT_DISPLAY, 32'h0000_0000,  1, 1'b0, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_DEQUEUE, 32'h0000_0000, 16, 1'b0, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_DEQUEUE, 32'h0000_0000,  1, 1'b1, ST_EMPTY,     32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'h5555_5555,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'hAAAA_AAAA,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_ENQUEUE, 32'h5555_5555,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_SEARCH,  32'h5555_5555,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd1},
        '{ACT_DISPLAY, 32'h0000_0000,  1, 1'b0, ST_OK,        32'h0000_0000, 5'd0},
        '{ACT_SEARCH,  32'hAAAA_AAAB,  1, 1'b1, ST_NOT_FOUND, 32'h0000_0000, 5'd0}
    };

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Applies one accepted request to the mirror and returns the words it causes.
    function automatic void apply_queue_action(input action_t act, input logic [31:0] word,
                                               output rsp_word_t words [$]);
        int  i;
        int  slot;
        bit  found;
        words = {};
        found = 1'b0;
        if (act == ACT_ENQUEUE)
        begin
            if (mirror_count == DEPTH)
            begin
                words.push_back('{ST_FULL, 32'd0, 5'd0, 1'b1});
            end
            else
            begin
                mirror_entries[mirror_tail] = word;
                mirror_tail = (mirror_tail + 1) % DEPTH;
                mirror_count++;
                words.push_back('{ST_OK, 32'd0, 5'd0, 1'b1});
            end
        end
        else if (mirror_count == 0)
        begin
            words.push_back('{ST_EMPTY, 32'd0, 5'd0, 1'b1});
        end
        else if (act == ACT_DEQUEUE)
        begin
            words.push_back('{ST_OK, mirror_entries[mirror_head], 5'd0, 1'b1});
            mirror_head = (mirror_head + 1) % DEPTH;
            mirror_count--;
        end
        else if (act == ACT_SEARCH)
        begin
            for (i = 0; i < mirror_count && !found; i++)
            begin
                slot = (mirror_head + i) % DEPTH;
                if (mirror_entries[slot] == word)
                begin
                    words.push_back('{ST_OK, 32'd0, 5'(i + 1), 1'b1});
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                words.push_back('{ST_NOT_FOUND, 32'd0, 5'd0, 1'b1});
            end
        end
        else
        begin
            for (i = 0; i < mirror_count; i++)
            begin
                slot = (mirror_head + i) % DEPTH;
                words.push_back('{ST_OK, mirror_entries[slot], 5'(i + 1),
                                  1'(i + 1 == mirror_count)});
            end
        end
    endfunction

    // Offers one request, waits for it to be taken and records what should come back.
    // The valid line is only lowered when a gap is inserted, so back-to-back
    // requests never see two assignments to it in one step.
    task automatic send_request(input action_t act, input logic [31:0] word,
                                input bit typed, input rsp_word_t typed_word);
        rsp_word_t words [$];
        int        gap;
        if (!quiet_run && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_queue_action(act, word, words);
        if (typed)
        begin
            awaited_words.push_back(typed_word);
        end
        else
        begin
            foreach (words[k])
            begin
                awaited_words.push_back(words[k]);
            end
        end
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            3, 4: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Receiver: checks each word taken and stalls in random bursts.
    initial
    begin
        rsp_word_t want;
        int        stall_left;
        int        hold_left;
        bit        hold_started;
        stall_left = 0;
        hold_left = 0;
        hold_started = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_words.size() == 0)
                begin
                    $error("unexpected response word: status %0d data %h position %0d last %0d",
                           rsp_ch.status, rsp_ch.data, rsp_ch.position, rsp_ch.last);
                    error_count++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.data !== want.data)
                    begin
                        $error("data: expected %h, got %h", want.data, rsp_ch.data);
                        error_count++;
                    end
                    if (rsp_ch.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position,
                               rsp_ch.position);
                        error_count++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                        error_count++;
                    end
                end
            end
            if (long_hold_req && !hold_started)
            begin
                hold_started = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_run && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Sender: reset, the directed table, then random traffic.
    initial
    begin
        action_t     act;
        logic [31:0] word;
        rsp_word_t   typed_word;
        int          fill_pct;
        int          roll;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_ENQUEUE;
        req_ch.value = 32'd0;
        error_count = 0;
        cycle_count = 0;
        long_hold_req = 1'b0;
        quiet_run = 1'b0;
        mirror_head = 0;
        mirror_tail = 0;
        mirror_count = 0;
        fill_pct = 50;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            typed_word = '{directed_rows[r].status, directed_rows[r].data,
                           directed_rows[r].position, 1'b1};
            for (int n = 0; n < directed_rows[r].reps; n++)
            begin
                send_request(directed_rows[r].act, directed_rows[r].word + 32'(n),
                             directed_rows[r].typed, typed_word);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Swing between filling and draining so both full and empty come up often.
            if (n % 30 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: fill_pct = 20;
                    1: fill_pct = 50;
                    default: fill_pct = 80;
                endcase
            end
            if (n == 120)
            begin
                long_hold_req <= 1'b1;
            end
            if (n == RANDOM_ITEMS - 60)
            begin
                quiet_run <= 1'b1;
            end
            roll = $urandom_range(0, 99);
            word = random_word();
            if (roll < fill_pct)
            begin
                act = ACT_ENQUEUE;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                begin
                    act = ACT_DEQUEUE;
                end
                else if (roll < 85)
                begin
                    act = ACT_SEARCH;
                    // Mostly look for a stored word, sometimes one bit off from it.
                    if (mirror_count > 0 && $urandom_range(0, 2) != 0)
                    begin
                        word = mirror_entries[(mirror_head + $urandom_range(0, mirror_count - 1))
                                              % DEPTH];
                        if ($urandom_range(0, 4) == 0)
                        begin
                            word[$urandom_range(0, 31)] ^= 1'b1;
                        end
                    end
                end
                else
                begin
                    act = ACT_DISPLAY;
                end
            end
            send_request(act, word, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (awaited_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
